@@ rtl/core/e2c_pkg.sv @@
// Package: constants, calendar table and lane result types for the epoch converter.
`timescale 1ns / 1ps

package e2c_pkg;

  localparam logic [31:0] EPOCH_2000   = 32'd946684800;
  localparam logic [31:0] SPAN_LAST    = 32'd4102444799;
  localparam logic [31:0] SECS_PER_DAY = 32'd86400;

  // floor(x / 86400) = (floor(x / 128) * DAY_RCP) >> DAY_SHIFT, exact over the span
  localparam logic [25:0] DAY_RCP   = 26'd50903317;
  localparam int          DAY_SHIFT = 35;

  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic [6:0] year_offset;
    logic [3:0] month;
    logic [4:0] day_of_month;
    logic [2:0] weekday;
  } date_t;

  // first day of year of month m (0 = January)
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    base = MONTH_START[m];
    if (leap && (m >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

@@ rtl/core/e2c_tod.sv @@
// Time-of-day lane: hour, minute and second from seconds within the day, four stages.
`timescale 1ns / 1ps

module e2c_tod (
  input  logic               clk,
  input  logic               en,
  input  logic [16:0]        sod,
  output e2c_pkg::tod_t      tod
);
  import e2c_pkg::*;

  logic [16:0] t1_sod;
  logic [4:0]  t1_hour;
  logic [11:0] t2_rem;
  logic [4:0]  t2_hour;
  logic [11:0] t3_rem;
  logic [5:0]  t3_min;
  logic [4:0]  t3_hour;

  logic [25:0] hour_mul;
  logic [16:0] hour_secs;
  logic [19:0] min_mul;
  logic [11:0] min_secs;

  // sod / 3600 = (sod >> 4) * 9321 >> 21
  assign hour_mul  = 26'(sod[16:4]) * 26'd9321;
  assign hour_secs = 17'(t1_hour) * 17'd3600;
  // rem / 60 = (rem >> 2) * 1093 >> 14
  assign min_mul   = 20'(t2_rem[11:2]) * 20'd1093;
  assign min_secs  = 12'(t3_min) * 12'd60;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_sod     <= sod;
      t1_hour    <= hour_mul[25:21];
      t2_rem     <= 12'(t1_sod - hour_secs);
      t2_hour    <= t1_hour;
      t3_rem     <= t2_rem;
      t3_min     <= min_mul[19:14];
      t3_hour    <= t2_hour;
      tod.hour   <= t3_hour;
      tod.minute <= t3_min;
      tod.second <= 6'(t3_rem - min_secs);
    end
  end

endmodule

@@ rtl/core/e2c_date.sv @@
// Date lane: year, month, day of month and weekday from days since 2000-01-01, four stages.
`timescale 1ns / 1ps

module e2c_date (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        day,
  output e2c_pkg::date_t     date
);
  import e2c_pkg::*;

  logic [15:0] d1_day;
  logic [15:0] d1_day6;
  logic [4:0]  d1_cyc;
  logic [12:0] d1_wq;
  logic [10:0] d2_rem;
  logic [4:0]  d2_cyc;
  logic [2:0]  d2_wd;
  logic [8:0]  d3_doy;
  logic [6:0]  d3_year;
  logic        d3_leap;
  logic [2:0]  d3_wd;

  logic [15:0] day6;
  logic [30:0] cyc_mul;
  logic [30:0] wk_mul;
  logic [10:0] r2;
  logic [6:0]  year_base;
  logic [6:0]  year_next;
  logic [8:0]  doy_next;
  logic        leap_next;
  logic [3:0]  mon;
  logic [8:0]  mon_base;

  assign day6    = day + 16'd6;
  // day / 1461 = day * 45934 >> 26, (day + 6) / 7 = (day + 6) * 37450 >> 18
  assign cyc_mul = 31'(day) * 31'd45934;
  assign wk_mul  = 31'(day6) * 31'd37450;

  // year within the four-year cycle; each cycle opens with a leap year
  always_comb begin
    year_base = 7'({d2_cyc, 2'b00});
    r2        = d2_rem - 11'd366;
    if (d2_rem < 11'd366) begin
      year_next = year_base;
      doy_next  = d2_rem[8:0];
      leap_next = 1'b1;
    end else if (r2 < 11'd365) begin
      year_next = year_base + 7'd1;
      doy_next  = r2[8:0];
      leap_next = 1'b0;
    end else if (r2 < 11'd730) begin
      year_next = year_base + 7'd2;
      doy_next  = 9'(r2 - 11'd365);
      leap_next = 1'b0;
    end else begin
      year_next = year_base + 7'd3;
      doy_next  = 9'(r2 - 11'd730);
      leap_next = 1'b0;
    end
  end

  always_comb begin
    mon = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (d3_doy >= month_start(4'(m), d3_leap)) begin
        mon = 4'(m);
      end
    end
    mon_base = month_start(mon, d3_leap);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_day            <= day;
      d1_day6           <= day6;
      d1_cyc            <= cyc_mul[30:26];
      d1_wq             <= wk_mul[30:18];
      d2_rem            <= 11'(d1_day - 16'(d1_cyc) * 16'd1461);
      d2_cyc            <= d1_cyc;
      d2_wd             <= 3'(d1_day6 - 16'(d1_wq) * 16'd7);
      d3_doy            <= doy_next;
      d3_year           <= year_next;
      d3_leap           <= leap_next;
      d3_wd             <= d2_wd;
      date.year_offset  <= d3_year;
      date.month        <= mon + 4'd1;
      date.day_of_month <= 5'(d3_doy - mon_base + 9'd1);
      date.weekday      <= d3_wd;
    end
  end

endmodule

@@ rtl/core/epoch_to_calendar_top.sv @@
// Top level: Unix timestamp to calendar date and time, eight-stage pipeline.
//
//  channel  dir  payload                                         handshake
//  s_*      in   tdata[31:0] epoch_seconds                       tvalid/tready
//  m_*      out  tdata[39:0] calendar fields, tuser out_of_range tvalid/tready
//
// One item per cycle unless the output stalls.
// Stage one subtracts EPOCH_2000; stages two to four split off days (reciprocal multiply,
// multiply-back, subtract); the time and date lanes then take four stages each.
// rst clears the stage valid bits only.
// A stall at the output freezes every stage at once; s_tready drops with it.
`timescale 1ns / 1ps

module epoch_to_calendar_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
  output logic        m_tvalid,
  input  logic        m_tready,
  // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month,
  // [25:22] month, [32:26] year_offset, [35:33] weekday, [39:36] zero
  output logic [39:0] m_tdata,
  output logic        m_tuser    // [0] out_of_range
);
  import e2c_pkg::*;

  localparam int Depth = 8;

  logic             en;
  logic [Depth-1:0] vld;
  logic [Depth-1:0] oor;

  logic [31:0] s1_t2;
  logic [31:0] s2_t2;
  logic [15:0] s2_day;
  logic [31:0] s3_t2;
  logic [31:0] s3_prod;
  logic [15:0] s3_day;
  logic [16:0] s4_sod;
  logic [15:0] s4_day;

  logic [50:0] day_mul;
  tod_t        tod;
  date_t       date;

  assign en       = !vld[Depth-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[Depth-1];

  assign day_mul = 51'(s1_t2[31:7]) * 51'(DAY_RCP);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oor     <= {oor[Depth-2:0], (s_tdata < EPOCH_2000) || (s_tdata > SPAN_LAST)};
      s1_t2   <= s_tdata - EPOCH_2000;
      s2_t2   <= s1_t2;
      s2_day  <= day_mul[50:DAY_SHIFT];
      s3_t2   <= s2_t2;
      s3_day  <= s2_day;
      s3_prod <= 32'(s2_day) * SECS_PER_DAY;
      s4_sod  <= 17'(s3_t2 - s3_prod);
      s4_day  <= s3_day;
    end
  end

  e2c_tod u_tod (
    .clk (clk),
    .en  (en),
    .sod (s4_sod),
    .tod (tod)
  );

  e2c_date u_date (
    .clk  (clk),
    .en   (en),
    .day  (s4_day),
    .date (date)
  );

  always_comb begin
    if (oor[Depth-1]) begin
      m_tdata = '0;
    end else begin
      m_tdata = {4'd0, date.weekday, date.year_offset, date.month, date.day_of_month,
                 tod.hour, tod.minute, tod.second};
    end
    m_tuser = oor[Depth-1];
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for epoch_to_calendar_top: random and directed timestamps, calendar predictor.
`timescale 1ns / 1ps

module tb_top;
  import e2c_pkg::*;

  localparam int unsigned SECS_DAY    = 86400;
  localparam int unsigned LAST_DAY    = 36524;     // 2099-12-31
  localparam int          RAND_ITEMS  = 1150;
  localparam int          DRAIN_AT    = 600;       // sender waits for empty pipe here
  localparam int          HOLD_AT     = 250;       // receiver starts its long hold-off here
  localparam int          HOLD_CYCLES = 120;
  localparam int          TAIL_CYCLES = 16;
  localparam int          MAX_CYCLES  = 300000;
  localparam int          MAX_PRINTS  = 40;

  typedef struct {
    logic [31:0] stamp;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [6:0]  year_offset;
    logic [2:0]  weekday;
    logic        out_of_range;
  } calendar_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;

  logic [31:0] stamp_q[$];        // items not yet offered
  calendar_t   calendar_q[$];     // expected results in order
  int          err_cnt = 0;
  int          sent_cnt = 0;
  int          got_cnt = 0;
  int          cycle_cnt = 0;

  epoch_to_calendar_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // calendar breakdown; four-year cycles each start with a leap year
  function automatic calendar_t to_calendar(input logic [31:0] stamp);
    calendar_t   cal;
    int unsigned secs, days, quad, doy, yr, mon, mlen;
    logic        leap;
    int unsigned mdays[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    cal = '{default: '0};
    cal.stamp = stamp;
    if (stamp < EPOCH_2000 || stamp > SPAN_LAST) begin
      cal.out_of_range = 1'b1;
      return cal;
    end
    secs = stamp - EPOCH_2000;
    cal.second = 6'(secs % 60);
    cal.minute = 6'((secs / 60) % 60);
    cal.hour   = 5'((secs / 3600) % 24);
    days = secs / SECS_DAY;
    cal.weekday = 3'((days + 6) % 7);   // 2000-01-01 was a Saturday
    quad = days / 1461;
    doy  = days % 1461;
    if (doy < 366) begin
      yr   = quad * 4;
      leap = 1'b1;
    end else begin
      doy  = doy - 366;
      yr   = quad * 4 + 1 + doy / 365;
      doy  = doy % 365;
      leap = 1'b0;
    end
    mon = 0;
    while (mon < 11) begin
      mlen = mdays[mon] + ((mon == 1 && leap) ? 1 : 0);
      if (doy < mlen) break;
      doy = doy - mlen;
      mon++;
    end
    cal.day_of_month = 5'(doy + 1);
    cal.month        = 4'(mon + 1);
    cal.year_offset  = 7'(yr);
    return cal;
  endfunction

  function automatic logic [31:0] stamp_at(input int unsigned day, input int unsigned sod);
    return EPOCH_2000 + day * SECS_DAY + sod;
  endfunction

  task automatic report(input string msg);
    if (err_cnt < MAX_PRINTS) $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // sender: bursts of random length, random gaps, one pause for a drained pipe
  int  burst_left = 0;
  int  gap_left = 0;
  bit  drain_wait = 1'b0;
  bit  drain_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        calendar_q.push_back(to_calendar(s_tdata));
        sent_cnt++;
        if (sent_cnt == DRAIN_AT && !drain_done) drain_wait = 1'b1;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (drain_wait && calendar_q.size() != 0) begin
          s_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (stamp_q.size() != 0) begin
          if (drain_wait) begin
            drain_wait = 1'b0;
            drain_done = 1'b1;
          end
          s_tvalid <= 1'b1;
          s_tdata  <= stamp_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall mode changes now and then, plus one long hold-off
  int  mode = 0;
  int  mode_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  calendar_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_cnt++;
        if (calendar_q.size() == 0) begin
          report($sformatf("unexpected result tdata=%h tuser=%b", m_tdata, m_tuser));
        end else begin
          want = calendar_q.pop_front();
          if (m_tdata[5:0] !== want.second)
            report($sformatf("stamp %0d second got %0d want %0d",
                             want.stamp, m_tdata[5:0], want.second));
          if (m_tdata[11:6] !== want.minute)
            report($sformatf("stamp %0d minute got %0d want %0d",
                             want.stamp, m_tdata[11:6], want.minute));
          if (m_tdata[16:12] !== want.hour)
            report($sformatf("stamp %0d hour got %0d want %0d",
                             want.stamp, m_tdata[16:12], want.hour));
          if (m_tdata[21:17] !== want.day_of_month)
            report($sformatf("stamp %0d day_of_month got %0d want %0d",
                             want.stamp, m_tdata[21:17], want.day_of_month));
          if (m_tdata[25:22] !== want.month)
            report($sformatf("stamp %0d month got %0d want %0d",
                             want.stamp, m_tdata[25:22], want.month));
          if (m_tdata[32:26] !== want.year_offset)
            report($sformatf("stamp %0d year_offset got %0d want %0d",
                             want.stamp, m_tdata[32:26], want.year_offset));
          if (m_tdata[35:33] !== want.weekday)
            report($sformatf("stamp %0d weekday got %0d want %0d",
                             want.stamp, m_tdata[35:33], want.weekday));
          if (m_tdata[39:36] !== 4'd0)
            report($sformatf("stamp %0d pad bits got %h", want.stamp, m_tdata[39:36]));
          if (m_tuser !== want.out_of_range)
            report($sformatf("stamp %0d out_of_range got %b want %b",
                             want.stamp, m_tuser, want.out_of_range));
        end
      end
      if (!hold_done && got_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 1);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned day, yr, pick;

    // range edges and 32-bit extremes
    stamp_q.push_back(32'h0000_0000);
    stamp_q.push_back(32'hFFFF_FFFF);
    stamp_q.push_back(EPOCH_2000 - 1);
    stamp_q.push_back(EPOCH_2000);
    stamp_q.push_back(SPAN_LAST);
    stamp_q.push_back(SPAN_LAST + 1);
    stamp_q.push_back(32'h7FFF_FFFF);
    stamp_q.push_back(32'h8000_0000);
    stamp_q.push_back(32'h5555_5555);
    stamp_q.push_back(32'hAAAA_AAAA);
    // leap day and year turns
    stamp_q.push_back(stamp_at(0, SECS_DAY - 1));
    stamp_q.push_back(stamp_at(58, 43200));
    stamp_q.push_back(stamp_at(59, 3661));             // 2000-02-29
    stamp_q.push_back(stamp_at(60, 0));                // 2000-03-01
    stamp_q.push_back(stamp_at(365, SECS_DAY - 1));    // 2000-12-31
    stamp_q.push_back(stamp_at(366, 0));               // 2001-01-01
    stamp_q.push_back(stamp_at(366 + 58, 59));         // 2001-02-28
    stamp_q.push_back(stamp_at(366 + 59, 60));         // 2001-03-01
    stamp_q.push_back(stamp_at(1460, SECS_DAY - 1));   // 2003-12-31
    stamp_q.push_back(stamp_at(1461, 0));              // 2004-01-01
    stamp_q.push_back(stamp_at(35064 + 59, 12345));    // 2096-02-29
    stamp_q.push_back(stamp_at(LAST_DAY, 0));
    stamp_q.push_back(stamp_at(LAST_DAY - 30, 86340)); // 2099-12-01 23:59:00

    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        stamp_q.push_back(stamp_at($urandom_range(0, LAST_DAY), $urandom_range(0, SECS_DAY - 1)));
      end else if (pick < 80) begin
        // around a year start, month ends reached by the day spread
        yr  = $urandom_range(0, 99);
        day = yr * 365 + (yr + 3) / 4 + $urandom_range(0, 2) * 59 + $urandom_range(0, 1);
        if (day > 0 && $urandom_range(0, 1) == 1) day = day - 1;
        if (day > LAST_DAY) day = LAST_DAY;
        stamp_q.push_back(stamp_at(day, $urandom_range(0, SECS_DAY - 1)));
      end else if (pick < 88) begin
        stamp_q.push_back($urandom_range(0, EPOCH_2000 - 1));
      end else if (pick < 93) begin
        stamp_q.push_back($urandom_range(SPAN_LAST + 1, 32'hFFFF_FFFF));
      end else begin
        stamp_q.push_back($urandom());
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (stamp_q.size() != 0 || s_tvalid || calendar_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (calendar_q.size() != 0)
      report($sformatf("%0d results never arrived", calendar_q.size()));
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
